// ===== sv/ir_pulse_distance_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_ENCODER_TOP_ASSERT_SVH
`define IR_PULSE_DISTANCE_ENCODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define IRPDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("irpde assertion failed");
`define IRPDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("irpde assertion failed");
`else
`define IRPDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IRPDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/irpde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance encoder package
// Widths, register indexes, reset durations and segment slot numbers.
// ----------------------------------------------------------------------------
package irpde_pkg;

	localparam int DUR_W     = 16;
	localparam int BYTE_W    = 8;
	localparam int NUM_REGS  = 6;
	localparam int REG_IDX_W = 3;
	localparam int SEG_W     = 5;

	typedef logic [DUR_W-1:0]     dur_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	typedef logic [SEG_W-1:0]     seg_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LEADER_MARK  = 3'd0,
		REG_LEADER_SPACE = 3'd1,
		REG_BIT_MARK     = 3'd2,
		REG_ZERO_SPACE   = 3'd3,
		REG_ONE_SPACE    = 3'd4,
		REG_STOP_MARK    = 3'd5
	} cfg_reg_t;

	localparam reg_idx_t REG_COUNT = reg_idx_t'(NUM_REGS);

	localparam dur_t REG_RESET [NUM_REGS] = '{
		16'd4500, 16'd4500, 16'd530, 16'd560, 16'd1690, 16'd560
	};

	// Segment slots of one byte: leader pair, eight mark/space pairs, stop.
	localparam seg_t SEG_LEADER_MARK  = 5'd0;
	localparam seg_t SEG_LEADER_SPACE = 5'd1;
	localparam seg_t SEG_BIT_FIRST    = 5'd2;
	localparam seg_t SEG_BIT_LAST     = 5'd17;
	localparam seg_t SEG_STOP         = 5'd18;

	localparam logic [2:0] BIT_MSB = 3'd7;

endpackage

// ===== sv/irpde_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance encoder channels
// Byte input, segment output and configuration write channels.
// ----------------------------------------------------------------------------
interface irpde_in_if;
	import irpde_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              first_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

interface irpde_out_if;
	import irpde_pkg::*;
	logic valid;
	logic ready;
	logic pin_level;
	dur_t duration_us;
	logic run_end;
	logic frame_end;

	modport source (output valid, output pin_level, output duration_us, output run_end,
		output frame_end, input ready);
	modport sink (input valid, input pin_level, input duration_us, input run_end,
		input frame_end, output ready);
endinterface

interface irpde_cfg_if;
	import irpde_pkg::*;
	logic     valid;
	logic     ready;
	reg_idx_t index;
	dur_t     wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/ir_pulse_distance_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse-distance encoder
// Expands each byte beat into NEC-style line segments (level and duration).
// ----------------------------------------------------------------------------
// Each accepted byte yields 16 segments, plus 2 for a leader when first_byte is
// set and 1 for a stop mark when last_byte is set, so 16 to 19 segment beats.
// One segment sequencer holds the current byte and steps one slot per cycle into
// the output register while that register is empty or its beat is being taken.
// The byte is first registered in the sequencer; its first segment is then
// loaded into the output register. The next byte is taken in the cycle that the
// current byte's final segment moves into the output register, so with no
// back-pressure and the next byte waiting, segments leave in an unbroken stream.
// Configuration writes are always accepted (ready is tied high); indexes 6 and 7 are dropped.
`include "ir_pulse_distance_encoder_top_assert.svh"

module ir_pulse_distance_encoder_top (
	input logic          clk,
	input logic          arst_n,
	irpde_in_if.sink     byte_in,
	irpde_out_if.source  seg_out,
	irpde_cfg_if.sink    cfg
);
	import irpde_pkg::*;

	// sequencer
	logic              busy_q;
	seg_t              seg_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// duration registers
	dur_t dur_q [NUM_REGS];

	// output register
	logic out_valid_q;
	logic pin_level_q;
	dur_t duration_q;
	logic run_end_q;
	logic frame_end_q;

	seg_t       seg_end;
	logic       at_end;
	logic       advance;
	logic       in_accept;
	seg_t       bit_pos;
	logic [2:0] bit_idx;
	logic       bit_val;
	logic       seg_level;
	dur_t       seg_dur;
	logic       seg_frame_end;

	assign seg_end   = last_s1 ? SEG_STOP : SEG_BIT_LAST;
	assign at_end    = (seg_q == seg_end);
	assign advance   = busy_q && (!out_valid_q || seg_out.ready);
	assign in_accept = byte_in.valid && byte_in.ready;

	// Take a byte when idle, or as soon as the final segment of the current one is moved into the output register.
	assign byte_in.ready = !busy_q || (advance && at_end);
	assign cfg.ready     = 1'b1;

	assign bit_pos = seg_q - SEG_BIT_FIRST;
	assign bit_idx = bit_pos[3:1];
	assign bit_val = byte_s1[BIT_MSB - bit_idx];

	always_comb begin
		seg_level     = 1'b0;
		seg_dur       = dur_q[REG_BIT_MARK];
		seg_frame_end = 1'b0;
		priority if (seg_q == SEG_LEADER_MARK) begin
			seg_dur = dur_q[REG_LEADER_MARK];
		end else if (seg_q == SEG_LEADER_SPACE) begin
			seg_level = 1'b1;
			seg_dur   = dur_q[REG_LEADER_SPACE];
		end else if (seg_q == SEG_STOP) begin
			seg_dur       = dur_q[REG_STOP_MARK];
			seg_frame_end = 1'b1;
		end else if (bit_pos[0]) begin
			seg_level = 1'b1;
			seg_dur   = bit_val ? dur_q[REG_ONE_SPACE] : dur_q[REG_ZERO_SPACE];
		end else begin
			seg_dur = dur_q[REG_BIT_MARK];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= SEG_LEADER_MARK;
		end else if (in_accept) begin
			busy_q <= 1'b1;
			seg_q  <= byte_in.first_byte ? SEG_LEADER_MARK : SEG_BIT_FIRST;
		end else if (advance) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				seg_q <= seg_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= byte_in.data_byte;
			last_s1 <= byte_in.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				dur_q[i] <= REG_RESET[i];
			end
		end else if (cfg.valid && cfg.ready && (cfg.index < REG_COUNT)) begin
			dur_q[cfg.index] <= cfg.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (seg_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the segment beat until taken.
	always_ff @(posedge clk) begin
		if (advance) begin
			pin_level_q <= seg_level;
			duration_q  <= seg_dur;
			run_end_q   <= at_end;
			frame_end_q <= seg_frame_end;
		end
	end

	assign seg_out.valid       = out_valid_q;
	assign seg_out.pin_level   = pin_level_q;
	assign seg_out.duration_us = duration_q;
	assign seg_out.run_end     = run_end_q;
	assign seg_out.frame_end   = frame_end_q;

	`IRPDE_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_accept, busy_q)
	`IRPDE_ASSERT_IMPLY(a_stop_closes_run, clk, arst_n,
		seg_out.valid && seg_out.frame_end, seg_out.run_end && !seg_out.pin_level)
	`IRPDE_ASSERT_NEXT(a_drain_idle, clk, arst_n,
		advance && at_end && !in_accept, !busy_q && out_valid_q && run_end_q)
	`IRPDE_ASSERT_IMPLY(a_seg_range, clk, arst_n, busy_q, seg_q <= seg_end)
	`IRPDE_ASSERT_IMPLY(a_ready_busy, clk, arst_n, byte_in.ready && busy_q, advance && at_end)

endmodule
